// File: rtl/asn_pkg.sv
`default_nettype none
package asn_pkg;
    localparam int FRAC_BITS = 30;
    localparam int ARG_W     = 32;
    localparam int ANG_W     = 32;
    localparam int HP_W      = 31;
    localparam int MAG_W     = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int TGT_W     = PROD_W - 1;
    localparam int RES_W     = 32;
    localparam int VAL_W     = RES_W + 3;
    localparam int DIV_W     = 8;           // divisor up to 2*MAX_TERMS+1
    localparam int DVD_W     = 32;
    localparam int DIV_BPC   = 8;           // quotient bits per cycle
    localparam int DIV_CYC   = DVD_W / DIV_BPC;
    localparam int DCNT_W    = $clog2(DIV_CYC);
    localparam int BIT_W     = $clog2(FRAC_BITS + 1);

    localparam logic [MAG_W-1:0] ONE       = MAG_W'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0] THREE_QTR = MAG_W'((3 * (64'd1 << FRAC_BITS)) >> 2);
    localparam logic [HP_W-1:0]  HALF_PI_RST = 31'd1686629713;
    localparam logic [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
    localparam logic [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

    typedef enum logic [4:0] {
        DP_IDLE, DP_LOAD, DP_SQ_MUL, DP_TGT, DP_RT_MUL, DP_RT_CMP, DP_RT_DONE,
        DP_TINIT, DP_CDIV, DP_DIV_STEP, DP_COEF, DP_PMUL1, DP_PMUL2, DP_POW,
        DP_TMUL, DP_TDIV, DP_ACC, DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_dom;
        logic is_refl;
        logic rt_last;
        logic div_last;
        logic term_zero;
    } t_dp_sts;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_SQ, S_TGT, S_RT_MUL, S_RT_CMP, S_RT_DONE, S_TINIT,
        S_CCHK, S_CDIV, S_COEF, S_PM1, S_PM2, S_POW, S_TMUL, S_TDIV0, S_TDIV,
        S_ACC, S_FIN
    } t_state;
endpackage
`default_nettype wire

// File: rtl/asn_arg_if.sv
`default_nettype none
interface asn_arg_if;
    logic                                valid;
    logic                                ready;
    logic signed [asn_pkg::ARG_W-1:0]    arg_value;
    modport source (output valid, output arg_value, input ready);
    modport sink   (input valid, input arg_value, output ready);
endinterface
`default_nettype wire

// File: rtl/asn_res_if.sv
`default_nettype none
interface asn_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [asn_pkg::ANG_W-1:0]    angle;
    logic                                domain_error;
    modport source (output valid, output angle, output domain_error, input ready);
    modport sink   (input valid, input angle, input domain_error, output ready);
endinterface
`default_nettype wire

// File: rtl/asn_dp.sv
`default_nettype none
module asn_dp (
    input  wire                          i_clk,
    input  wire                          i_cfg_wr_en,
    input  wire  [asn_pkg::HP_W-1:0]     i_cfg_wr_data,
    input  wire                          i_rst_n,
    input  wire  [asn_pkg::ARG_W-1:0]    i_arg,
    input  asn_pkg::t_dp_cmd             i_cmd,
    output asn_pkg::t_dp_sts             o_sts,
    output logic [asn_pkg::ANG_W-1:0]    o_angle,
    output logic                         o_dom
);
    import asn_pkg::*;

    logic [HP_W-1:0]   r_half_pi;
    logic              r_neg, r_dom, r_refl;
    logic [MAG_W-1:0]  r_y, r_coef, r_powy, r_root;
    logic [DIV_W-1:0]  r_i, r_dvs;
    logic [PROD_W-1:0] r_prod;
    logic [TGT_W-1:0]  r_tgt;
    logic [BIT_W-1:0]  r_bit;
    logic [RES_W-1:0]  r_res;
    logic [DVD_W-1:0]  r_quo, n_quo;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic [ANG_W-1:0]  r_angle;
    logic              r_odom;

    logic [MAG_W-1:0]  mul_a, mul_b, cand;
    logic              mul_en;
    logic [ARG_W-1:0]  mag;
    logic [DIV_W:0]    rem_x;
    logic signed [VAL_W-1:0] val;
    logic [ANG_W-1:0]  ang;

    assign mag  = i_arg[ARG_W-1] ? (~i_arg + ARG_W'(1)) : i_arg;
    assign cand = r_root | (MAG_W'(1) << r_bit);

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (i_cmd.op)
            DP_SQ_MUL: begin mul_a = r_y;    mul_b = r_y;  end
            DP_RT_MUL: begin mul_a = cand;   mul_b = cand; end
            DP_PMUL1:  begin mul_a = r_powy; mul_b = r_y;  end
            DP_PMUL2:  begin mul_a = r_prod[FRAC_BITS +: MAG_W]; mul_b = r_y; end
            DP_TMUL:   begin mul_a = r_coef; mul_b = r_powy; end
            default:   mul_en = 1'b0;
        endcase
    end

    // restoring divide, DIV_BPC quotient bits per cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        rem_x = '0;
        for (int k = 0; k < DIV_BPC; k++) begin
            rem_x = {n_rem, n_quo[DVD_W-1]};
            n_quo = {n_quo[DVD_W-2:0], 1'b0};
            if (rem_x >= {1'b0, r_dvs}) begin
                rem_x    = rem_x - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = rem_x[DIV_W-1:0];
        end
    end

    // sign, reflection, saturation and domain-error override
    always_comb begin
        val = r_refl ? ($signed({{(VAL_W-HP_W){1'b0}}, r_half_pi})
                        - $signed({{(VAL_W-RES_W){1'b0}}, r_res}))
                     : $signed({{(VAL_W-RES_W){1'b0}}, r_res});
        if (r_neg)
            val = -val;
        if (val > $signed({{(VAL_W-ANG_W){1'b0}}, ANG_MAX}))
            ang = ANG_MAX;
        else if (val < $signed({{(VAL_W-ANG_W){1'b1}}, ANG_MIN}))
            ang = ANG_MIN;
        else
            ang = val[ANG_W-1:0];
        if (r_dom)
            ang = r_neg ? ANG_MIN : ANG_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_pi <= HALF_PI_RST;
        end else if (i_cfg_wr_en) begin
            r_half_pi <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en)
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        case (i_cmd.op)
            DP_LOAD: begin
                r_neg  <= i_arg[ARG_W-1];
                r_dom  <= mag > ARG_W'(ONE);
                r_refl <= mag > ARG_W'(THREE_QTR);
                r_y    <= mag[MAG_W-1:0];
            end
            DP_TGT: begin
                r_tgt  <= {ONE - r_prod[FRAC_BITS +: MAG_W], {FRAC_BITS{1'b0}}};
                r_root <= '0;
                r_bit  <= BIT_W'(FRAC_BITS);
            end
            DP_RT_CMP: begin
                if (r_prod <= {1'b0, r_tgt})
                    r_root <= cand;
                r_bit <= r_bit - BIT_W'(1);
            end
            DP_RT_DONE: r_y <= r_root;
            DP_TINIT: begin
                r_res  <= RES_W'(r_y);
                r_coef <= ONE;
                r_powy <= r_y;
                r_i    <= DIV_W'(1);
            end
            DP_CDIV: begin
                // coef - ceil(coef/(i+1)) == coef - floor((coef+i)/(i+1))
                r_quo  <= DVD_W'(r_coef) + DVD_W'(r_i);
                r_dvs  <= r_i + DIV_W'(1);
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            DP_DIV_STEP: begin
                r_quo  <= n_quo;
                r_rem  <= n_rem;
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            DP_COEF: r_coef <= r_coef - r_quo[MAG_W-1:0];
            DP_POW:  r_powy <= r_prod[FRAC_BITS +: MAG_W];
            DP_TDIV: begin
                r_quo  <= r_prod[FRAC_BITS +: DVD_W];
                r_dvs  <= r_i + DIV_W'(2);
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            DP_ACC: begin
                r_res <= r_res + RES_W'(r_quo);
                r_i   <= r_i + DIV_W'(2);
            end
            DP_FINISH: begin
                r_angle <= ang;
                r_odom  <= r_dom;
            end
            default: ;
        endcase
    end

    assign o_sts.is_dom    = r_dom;
    assign o_sts.is_refl   = r_refl;
    assign o_sts.rt_last   = (r_bit == '0);
    assign o_sts.div_last  = (r_dcnt == DCNT_W'(DIV_CYC - 1));
    assign o_sts.term_zero = (r_quo == '0);
    assign o_angle = r_angle;
    assign o_dom   = r_odom;
endmodule
`default_nettype wire

// File: rtl/asn_ctrl.sv
`default_nettype none
module asn_ctrl #(
    parameter int MAX_TERMS = 40
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  asn_pkg::t_dp_sts  i_sts,
    output asn_pkg::t_dp_cmd  o_cmd
);
    import asn_pkg::*;

    localparam int N_W = $clog2(MAX_TERMS + 1);

    t_state          r_state, n_state;
    logic [N_W-1:0]  r_n, n_n;
    logic            r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_ovalid   = r_ovalid && !i_out_ready;
        o_cmd.op   = DP_IDLE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.is_dom)       n_state = S_FIN;
                else if (i_sts.is_refl) n_state = S_SQ;
                else                    n_state = S_TINIT;
            end
            S_SQ:     begin o_cmd.op = DP_SQ_MUL; n_state = S_TGT;    end
            S_TGT:    begin o_cmd.op = DP_TGT;    n_state = S_RT_MUL; end
            S_RT_MUL: begin o_cmd.op = DP_RT_MUL; n_state = S_RT_CMP; end
            S_RT_CMP: begin
                o_cmd.op = DP_RT_CMP;
                n_state  = i_sts.rt_last ? S_RT_DONE : S_RT_MUL;
            end
            S_RT_DONE: begin o_cmd.op = DP_RT_DONE; n_state = S_TINIT; end
            S_TINIT: begin
                o_cmd.op = DP_TINIT;
                n_n      = '0;
                n_state  = S_CCHK;
            end
            S_CCHK: begin
                if (r_n == N_W'(MAX_TERMS)) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = DP_CDIV;
                    n_state  = S_CDIV;
                end
            end
            S_CDIV: begin
                o_cmd.op = DP_DIV_STEP;
                if (i_sts.div_last) n_state = S_COEF;
            end
            S_COEF:  begin o_cmd.op = DP_COEF;  n_state = S_PM1;   end
            S_PM1:   begin o_cmd.op = DP_PMUL1; n_state = S_PM2;   end
            S_PM2:   begin o_cmd.op = DP_PMUL2; n_state = S_POW;   end
            S_POW:   begin o_cmd.op = DP_POW;   n_state = S_TMUL;  end
            S_TMUL:  begin o_cmd.op = DP_TMUL;  n_state = S_TDIV0; end
            S_TDIV0: begin o_cmd.op = DP_TDIV;  n_state = S_TDIV;  end
            S_TDIV: begin
                o_cmd.op = DP_DIV_STEP;
                if (i_sts.div_last) n_state = S_ACC;
            end
            S_ACC: begin
                if (i_sts.term_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = DP_ACC;
                    n_n      = r_n + N_W'(1);
                    n_state  = S_CCHK;
                end
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = DP_FINISH;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_ovalid;

    a_n_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_W'(MAX_TERMS))
        else $error("term count past limit");
    a_load_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_LOAD) |-> (i_in_valid && o_in_ready))
        else $error("load without accepted request");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_FINISH) |-> (!r_ovalid || i_out_ready))
        else $error("result overwritten before taken");
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_FINISH) |=> r_ovalid)
        else $error("finished result not presented");
endmodule
`default_nettype wire

// File: rtl/fixed_point_arcsine_core.sv
`default_nettype none
// Fixed-point arcsine, signed Q2.30 in and out. One request at a time: a
// controller sequences a datapath built around one shared 31x31 multiplier
// and an 8-bit-per-cycle divider. Domain error (|x| > 1.0) goes straight
// to the result. For |x| <= 0.75 the series is summed term by term, up to
// MAX_TERMS terms (typically 20-40 terms at Q2.30). For |x| > 0.75 the
// reflection adds a bit-serial square root (one multiply and one compare
// per root bit) plus squaring, target setup and root hand-off. The next
// request is taken as soon as the previous result is in the output
// register; a new result waits in S_FIN only if the previous one has not
// been taken yet. half_pi must be written through i_cfg_wr_en/i_cfg_wr_data
// only while idle; the block itself does not enforce this.
module fixed_point_arcsine_core #(
    parameter int MAX_TERMS = 40
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire  [asn_pkg::HP_W-1:0]    i_cfg_wr_data,
    asn_arg_if.sink                     i_arg,
    asn_res_if.source                   o_res
);
    import asn_pkg::*;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [ANG_W-1:0] angle;
    logic             dom;

    asn_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_arg.valid),
        .o_in_ready  (i_arg.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    asn_dp u_dp (
        .i_clk         (i_clk),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rst_n       (i_rst_n),
        .i_arg         (i_arg.arg_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_angle       (angle),
        .o_dom         (dom)
    );

    assign o_res.angle        = angle;
    assign o_res.domain_error = dom;
endmodule
`default_nettype wire

// File: bench/fixed_point_arcsine_core_test.sv
`default_nettype none
module fixed_point_arcsine_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import asn_pkg::*;

    localparam int          TERM_LIMIT = 40;
    localparam int          STALL_LIMIT = 20000;   // cycles with no handshake at all
    localparam int          SETTLE = 40;           // quiet cycles before a config write / end
    localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS;

    typedef struct packed {
        logic [ANG_W-1:0] angle;
        logic             domain_error;
    } t_angle_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [HP_W-1:0] i_cfg_wr_data = '0;

    asn_arg_if arg_ch();
    asn_res_if res_ch();

    fixed_point_arcsine_core #(.MAX_TERMS(TERM_LIMIT)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_arg        (arg_ch),
        .o_res        (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // bench-side copy of the one register
    logic [HP_W-1:0] half_pi_shadow = HALF_PI_RST;
    t_angle_result   pending_angles[$];
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              mismatches = 0;
    int              requests_sent = 0;
    int              results_seen = 0;
    int              domain_hits = 0;
    int              idle_cycles = 0;

    initial begin
        arg_ch.valid     = 1'b0;
        arg_ch.arg_value = '0;
        res_ch.ready     = 1'b0;
    end

    // Taylor sum of asin(y), y unsigned with FRAC_BITS fraction bits.
    function automatic logic [63:0] taylor_asin(logic [63:0] y);
        logic [63:0]  sum, coef, powy, idx, term;
        logic [127:0] prod;
        sum  = y;
        coef = UNIT;
        powy = y;
        idx  = 64'd1;
        for (int n = 0; n < TERM_LIMIT; n++) begin
            coef = coef - (coef + idx) / (idx + 64'd1);
            powy = (((powy * y) >> FRAC_BITS) * y) >> FRAC_BITS;
            prod = {64'd0, coef} * {64'd0, powy};
            term = 64'((prod >> FRAC_BITS) / {64'd0, idx + 64'd2});
            if (term == 0) break;
            sum = sum + term;
            idx = idx + 64'd2;
        end
        return sum;
    endfunction

    // floor(sqrt((1 - y*y) * 2^FRAC_BITS)), bit by bit from the top
    function automatic logic [63:0] cos_of_asin(logic [63:0] y);
        logic [63:0] target, root, trial;
        target = (UNIT - ((y * y) >> FRAC_BITS)) << FRAC_BITS;
        root   = 0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= target) root = trial;
        end
        return root;
    endfunction

    function automatic t_angle_result arcsine_of(logic [ARG_W-1:0] x);
        t_angle_result r;
        logic          neg;
        logic [63:0]   mag;
        longint        val;
        neg = x[ARG_W-1];
        mag = {32'd0, neg ? -x : x};   // -0x80000000 stays 0x80000000
        if (mag > UNIT) begin
            r.angle        = neg ? ANG_MIN : ANG_MAX;
            r.domain_error = 1'b1;
            return r;
        end
        if (mag > ((UNIT * 3) >> 2))
            val = longint'({33'd0, half_pi_shadow}) - longint'(taylor_asin(cos_of_asin(mag)));
        else
            val = longint'(taylor_asin(mag));
        if (neg) val = -val;
        if (val > 64'sh7FFF_FFFF) val = 64'sh7FFF_FFFF;
        if (val < -64'sh8000_0000) val = -64'sh8000_0000;
        r.angle        = val[31:0];
        r.domain_error = 1'b0;
        return r;
    endfunction

    // Receiver: random backpressure, re-rolled every cycle.
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: oldest expectation first.
    always @(posedge i_clk) begin
        t_angle_result got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.angle        = res_ch.angle;
            got.domain_error = res_ch.domain_error;
            results_seen++;
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result angle=%h dom=%b", got.angle, got.domain_error);
            end else begin
                want = pending_angles.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected angle=%h dom=%b, got angle=%h dom=%b",
                                 want.angle, want.domain_error, got.angle, got.domain_error);
                end
            end
        end
    end

    // Watchdog: any handshake resets the count.
    always @(posedge i_clk) begin
        if ((arg_ch.valid && arg_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Sends one request; valid stays high across back-to-back requests.
    task automatic send_arg(logic [ARG_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            arg_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        arg_ch.valid     <= 1'b1;
        arg_ch.arg_value <= x;
        do @(posedge i_clk); while (!arg_ch.ready);
        pending_angles.push_back(arcsine_of(x));
        requests_sent++;
        if (x[ARG_W-1] ? (-x > UNIT[31:0]) : (x > UNIT[31:0])) domain_hits++;
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic drain();
        arg_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_half_pi(logic [HP_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        half_pi_shadow = v;
    endtask

    // Mostly in-domain values; some beyond +-1.0 and some fully random words.
    function automatic logic [ARG_W-1:0] random_arg();
        logic [ARG_W-1:0] m;
        case ($urandom_range(9))
            0:       return $urandom();
            1:       m = UNIT[31:0] + $urandom_range(32'h7FFF_FFFF - UNIT[31:0], 1);
            2, 3:    m = $urandom_range(UNIT[31:0], 32'h3000_0000);   // reflection band
            4:       m = $urandom_range(32'h0000_FFFF);                // tiny, short series
            default: m = $urandom_range(32'h3000_0000);
        endcase
        return $urandom_range(1) ? -m : m;
    endfunction

    task automatic test_edges();
        logic [ARG_W-1:0] edges[] = '{
            32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h4000_0000, 32'hC000_0000,
            32'h4000_0001, 32'hBFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h3000_0000,
            32'h3000_0001, 32'hD000_0000, 32'hCFFF_FFFF, 32'h3FFF_FFFF, 32'h2000_0000,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h0800_0000};
        foreach (edges[k]) send_arg(edges[k]);
    endtask

    // Reflection band, +-1.0 and one small direct value under extreme / odd half_pi values.
    task automatic test_half_pi_settings();
        logic [HP_W-1:0] settings[] = '{31'd0, 31'h7FFF_FFFF, 31'd12345, HALF_PI_RST + 31'd1};
        foreach (settings[k]) begin
            write_half_pi(settings[k]);
            send_arg(32'h4000_0000);
            send_arg(32'hC000_0000);
            send_arg(32'h3800_0000);
            send_arg(32'hC800_0000);
            send_arg(32'h1000_0000);
        end
        write_half_pi(HALF_PI_RST);
    endtask

    task automatic test_random(int s_idle, int r_idle, int count);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int k = 0; k < count; k++) begin
            send_arg(random_arg());
            if (k == count / 2) drain();   // hold off until everything has come back
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges();
        test_half_pi_settings();
        test_random(20, 65, 200);
        test_random(65, 20, 200);
        test_random(0, 0, 200);
        drain();
        $display("%0d requests (%0d out of domain), %0d results, 5 half_pi values",
                 requests_sent, domain_hits, results_seen);
        if (mismatches == 0 && pending_angles.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
rtl/asn_pkg.sv
rtl/asn_arg_if.sv
rtl/asn_res_if.sv
rtl/asn_dp.sv
rtl/asn_ctrl.sv
rtl/fixed_point_arcsine_core.sv
bench/fixed_point_arcsine_core_test.sv
